// ----- src/amq_pkg.sv -----
`default_nettype none
package amq_pkg;

  // sizing
  localparam int QUEUE_DEPTH = 1024;
  localparam int TIME_WIDTH  = 48;
  localparam int COUNT_W     = 11;
  localparam int NOW_W       = 48;
  localparam int AREA_W      = 64;
  localparam int PROD_W      = COUNT_W + TIME_WIDTH;
  localparam int SUM_W       = ((PROD_W > AREA_W) ? PROD_W : AREA_W) + 1;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] REG_QUEUE_LIMIT = 1'b0;
  localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(200);

  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [TIME_WIDTH-1:0] time_t;
  typedef logic [AREA_W-1:0]     area_t;

  typedef enum logic {
    FUNC_ENQ = 1'b0,
    FUNC_DEQ = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    VERDICT_SCHED = 3'd0,
    VERDICT_SEND  = 3'd1,
    VERDICT_DROP  = 3'd2,
    VERDICT_DEQ   = 3'd3,
    VERDICT_ERR   = 3'd4
  } verdict_t;

  // one input word
  typedef struct packed {
    func_t             func;
    logic [NOW_W-1:0]  now_ns;
    logic              must_queue;
  } amq_word_t;

endpackage
`default_nettype wire

// ----- src/amq_cfg_regs.sv -----
`default_nettype none
module amq_cfg_regs
  import amq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready,
  output count_t                     queue_limit
);

  count_t     queue_limit_r;
  count_t     queue_limit_nxt;
  logic [0:0] reg_index;
  logic       wr_en;

  // register index from the word address
  assign reg_index = cfg_paddr[2:2];
  assign wr_en     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    queue_limit_nxt = queue_limit_r;
    if (wr_en && (reg_index == REG_QUEUE_LIMIT)) begin
      queue_limit_nxt = cfg_pwdata[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_limit_r <= LIMIT_RESET;
    end else begin
      queue_limit_r <= queue_limit_nxt;
    end
  end

  // read back
  always_comb begin
    cfg_prdata = '0;
    if (reg_index == REG_QUEUE_LIMIT) begin
      cfg_prdata = CFG_DATA_W'(queue_limit_r);
    end
  end

  assign cfg_pready  = 1'b1;
  assign queue_limit = queue_limit_r;

endmodule
`default_nettype wire

// ----- src/amq_in_reg.sv -----
`default_nettype none
module amq_in_reg
  import amq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire amq_word_t in_word,
  output logic           word_valid,
  output amq_word_t      word,
  input  wire logic      word_take
);

  logic      valid_r;
  logic      valid_nxt;
  amq_word_t word_r;
  logic      accept;

  // take a new word when the register is empty or the held one leaves in the same cycle
  assign in_ready = !valid_r || word_take;
  assign accept   = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (word_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload holds until replaced
  always_ff @(posedge clk) begin
    if (accept) begin
      word_r <= in_word;
    end
  end

  assign word_valid = valid_r;
  assign word       = word_r;

endmodule
`default_nettype wire

// ----- src/amq_policy.sv -----
`default_nettype none
module amq_policy
  import amq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire count_t    queue_limit,
  input  wire logic      word_valid,
  input  wire amq_word_t word,
  output logic           word_take,
  output logic           out_valid,
  input  wire logic      out_ready,
  output verdict_t       verdict,
  output logic           congestion_mark,
  output count_t         queue_length
);

  // queue state
  count_t   queue_count_r;
  count_t   queue_count_nxt;
  area_t    area_sum_r;
  area_t    area_sum_nxt;
  time_t    last_time_r;
  time_t    last_time_nxt;

  // result register
  logic     out_valid_r;
  logic     out_valid_nxt;
  verdict_t verdict_r;
  verdict_t verdict_nxt;
  logic     mark_r;
  logic     mark_nxt;
  count_t   length_r;

  time_t              now;
  time_t              delta;
  logic [PROD_W-1:0]  prod;
  logic [SUM_W-1:0]   sum_wide;
  area_t              area_acc;
  logic               now_zero;
  logic               full;

  assign word_take = word_valid && (!out_valid_r || out_ready);

  // time step and area increment
  assign now      = word.now_ns[TIME_WIDTH-1:0];
  assign delta    = (now > last_time_r) ? (now - last_time_r) : '0;
  assign prod     = PROD_W'(queue_count_r) * PROD_W'(delta);
  assign sum_wide = SUM_W'(area_sum_r) + SUM_W'(prod);
  assign area_acc = (sum_wide[SUM_W-1:AREA_W] != '0) ? '1 : sum_wide[AREA_W-1:0];
  assign now_zero = (now == '0);
  assign full     = (queue_count_r >= queue_limit) ||
                    (32'(queue_count_r) >= 32'(QUEUE_DEPTH));

  // decision
  always_comb begin
    queue_count_nxt = queue_count_r;
    area_sum_nxt    = area_sum_r;
    last_time_nxt   = last_time_r;
    verdict_nxt     = verdict_r;
    mark_nxt        = mark_r;
    out_valid_nxt   = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (word_take) begin
      out_valid_nxt = 1'b1;
      mark_nxt      = 1'b0;
      if (word.func == FUNC_ENQ) begin
        if (full) begin
          verdict_nxt = VERDICT_DROP;
        end else begin
          area_sum_nxt  = area_acc;
          last_time_nxt = now;
          if (now_zero) begin
            verdict_nxt = VERDICT_ERR;
          end else begin
            mark_nxt = (area_acc >= AREA_W'(now));
            if (!word.must_queue && (queue_count_r == '0)) begin
              verdict_nxt = VERDICT_SEND;
            end else begin
              verdict_nxt     = VERDICT_SCHED;
              queue_count_nxt = queue_count_r + COUNT_W'(1);
            end
          end
        end
      end else begin
        if (queue_count_r == '0) begin
          verdict_nxt = VERDICT_ERR;
        end else begin
          area_sum_nxt    = area_acc;
          last_time_nxt   = now;
          queue_count_nxt = queue_count_r - COUNT_W'(1);
          verdict_nxt     = now_zero ? VERDICT_ERR : VERDICT_DEQ;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queue_count_r <= '0;
      area_sum_r    <= '0;
      last_time_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      queue_count_r <= queue_count_nxt;
      area_sum_r    <= area_sum_nxt;
      last_time_r   <= last_time_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    verdict_r <= verdict_nxt;
    mark_r    <= mark_nxt;
    if (word_take) begin
      length_r <= queue_count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign verdict         = verdict_r;
  assign congestion_mark = mark_r;
  assign queue_length    = length_r;

`ifndef SYNTHESIS
  // only enqueues that are scheduled or sent carry a mark
  a_mark_only_on_enqueue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && mark_r) |-> (verdict_r == VERDICT_SCHED || verdict_r == VERDICT_SEND))
    else $error("congestion mark on a non-enqueue verdict");

  // queue never grows past the storage depth
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    32'(queue_count_r) <= 32'(QUEUE_DEPTH))
    else $error("queue count above depth");

  // area only grows or saturates
  a_area_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (area_sum_r >= $past(area_sum_r)))
    else $error("area sum decreased");

  // a dequeue of a non-empty queue removes exactly one packet
  a_deq_decrements: assert property (@(posedge clk) disable iff (!rst_n)
    (word_take && word.func == FUNC_DEQ && queue_count_r != '0)
      |=> (queue_count_r == $past(queue_count_r) - COUNT_W'(1)))
    else $error("dequeue did not decrement the count");
`endif

endmodule
`default_nettype wire

// ----- src/avg_queue_congestion_marker_core.sv -----
`default_nettype none
// Average queue length congestion marker for one port.
// Input channel (in_valid/in_ready): one word per enqueue or dequeue event,
// with its timestamp in ns and the force-queue flag.
// Result channel (out_valid/out_ready): one word per input word, carrying the
// verdict, the congestion mark and the queue length after the event.
// Config: APB-style port, queue_limit at byte address 0, pready tied high.
// Path: an accepted word sits in the input register, and the policy then
// registers its result in the result register, from which it is taken.
// Throughput: one word per cycle while the result is taken; the state update (11 x 48
// bit multiply, 64 bit saturating add and compare) is combinational, so each word
// sees the state left by the word before it.
// Stall: while out_ready is low the result holds; one more word can sit in
// the input register, after which in_ready drops until the result is taken.
// Reset (synchronous rst_n low): queue count, area and last event time go to
// zero, queue_limit to 200, both channels empty.
module avg_queue_congestion_marker_core
  import amq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_func,
  input  wire logic [NOW_W-1:0]      in_now_ns,
  input  wire logic                  in_must_queue,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [2:0]                 out_verdict,
  output logic                       out_congestion_mark,
  output logic [COUNT_W-1:0]         out_queue_length,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  count_t    queue_limit;
  amq_word_t in_word;
  amq_word_t word;
  logic      word_valid;
  logic      word_take;
  verdict_t  verdict;
  count_t    queue_length;

  assign in_word = '{func: func_t'(in_func), now_ns: in_now_ns, must_queue: in_must_queue};

  amq_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .queue_limit (queue_limit)
  );

  amq_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .word_valid (word_valid),
    .word       (word),
    .word_take  (word_take)
  );

  amq_policy u_policy (
    .clk             (clk),
    .rst_n           (rst_n),
    .queue_limit     (queue_limit),
    .word_valid      (word_valid),
    .word            (word),
    .word_take       (word_take),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .verdict         (verdict),
    .congestion_mark (out_congestion_mark),
    .queue_length    (queue_length)
  );

  assign out_verdict      = 3'(verdict);
  assign out_queue_length = queue_length;

endmodule
`default_nettype wire
